// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NSV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nsv_pkg.sv =====
// ---------------------------------------------------------------------------
// nsv_pkg
// Widths, defaults, request codes and shared types of the search block.
// ---------------------------------------------------------------------------
package nsv_pkg;

    localparam int VALUE_BITS = 16;
    localparam int POS_W      = 14;
    localparam int SIZE_W     = 15;
    localparam int THR_W      = 17;
    localparam int KIND_W     = 2;

    localparam int DEF_ENTRIES      = 16384;
    localparam int DEF_BLOCK_SIZE   = 64;
    localparam int DEF_GROUP_BLOCKS = 64;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FWD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BWD   = 2'd2;

    // minima store controls issued by the sequencer
    typedef struct packed {
        logic blk_rd;
        logic blk_wr;
        logic grp_wr;
    } min_ctl_t;

    // position width: covers the size register, the array and one group span
    function automatic int pos_width(input int entries, input int span);
        int w;
        w = SIZE_W;
        if ($clog2(entries) > w)
            w = $clog2(entries);
        if ($clog2(span) > w)
            w = $clog2(span);
        return w + 1;
    endfunction

endpackage

// ===== rtl/core/nsv_ifs.sv =====
// ---------------------------------------------------------------------------
// nsv request / response channels
// Valid/ready channels carrying one request word and one result word.
// ---------------------------------------------------------------------------
interface nsv_req_if
    import nsv_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [POS_W-1:0]      entry_pos;
    logic [VALUE_BITS-1:0] write_value;
    logic [THR_W-1:0]      threshold;

    modport source (output valid, kind, entry_pos, write_value, threshold, input ready);
    modport sink   (input valid, kind, entry_pos, write_value, threshold, output ready);
endinterface

interface nsv_rsp_if
    import nsv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] result_pos;
    logic              found;

    modport source (output valid, result_pos, found, input ready);
    modport sink   (input valid, result_pos, found, output ready);
endinterface

// ===== rtl/core/nsv_ram.sv =====
// ---------------------------------------------------------------------------
// nsv_ram
// Single-port RAM, read-first, registered read data.
// ---------------------------------------------------------------------------
module nsv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/nsv_minima.sv =====
// ---------------------------------------------------------------------------
// nsv_minima
// Block minima (RAM plus valid bits) and group minima (flops).
// ---------------------------------------------------------------------------
module nsv_minima
    import nsv_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_ENTRIES / DEF_BLOCK_SIZE,
    parameter int NUM_GROUPS = 4
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  min_ctl_t                                         ctl,
    input  logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] blk_addr,
    input  logic [(NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1)-1:0] grp_idx,
    input  logic [VALUE_BITS-1:0]                            wr_val,
    output logic [VALUE_BITS-1:0]                            grp_min,
    output logic [VALUE_BITS-1:0]                            blk_min
);

    localparam logic [VALUE_BITS-1:0] ONES = {VALUE_BITS{1'b1}};

    logic [NUM_BLOCKS-1:0] blk_vld_reg;
    logic                  vld_q_reg;
    logic [VALUE_BITS-1:0] grp_min_reg [NUM_GROUPS];
    logic [VALUE_BITS-1:0] ram_q;
    logic [VALUE_BITS-1:0] blk_new;

    nsv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_blk_ram (
        .clk   (clk),
        .en    (ctl.blk_rd | ctl.blk_wr),
        .we    (ctl.blk_wr),
        .addr  (blk_addr),
        .wdata (blk_new),
        .rdata (ram_q)
    );

    // a block never written reads as all ones
    assign blk_min = vld_q_reg ? ram_q : ONES;
    assign blk_new = (wr_val < blk_min) ? wr_val : blk_min;
    assign grp_min = (int'(grp_idx) < NUM_GROUPS) ? grp_min_reg[grp_idx] : ONES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_vld_reg <= '0;
            vld_q_reg   <= 1'b0;
            for (int i = 0; i < NUM_GROUPS; i++)
                grp_min_reg[i] <= ONES;
        end
        else
        begin
            if (ctl.blk_rd)
                vld_q_reg <= blk_vld_reg[blk_addr];
            if (ctl.blk_wr)
                blk_vld_reg[blk_addr] <= 1'b1;
            if (ctl.grp_wr && (wr_val < grp_min))
                grp_min_reg[grp_idx] <= wr_val;
        end
    end

endmodule

// ===== rtl/core/nsv_walk.sv =====
// ---------------------------------------------------------------------------
// nsv_walk
// Sequencer: splits the start position, then steps one position, block or
// group at a time through a shared step unit, testing minima and values.
// ---------------------------------------------------------------------------
module nsv_walk
    import nsv_pkg::*;
#(
    parameter int ENTRIES      = DEF_ENTRIES,
    parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE,
    parameter int GROUP_BLOCKS = DEF_GROUP_BLOCKS,
    localparam int NUM_BLOCKS  = (ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE,
    localparam int NUM_GROUPS  = (NUM_BLOCKS + GROUP_BLOCKS - 1) / GROUP_BLOCKS,
    localparam int SPAN        = BLOCK_SIZE * GROUP_BLOCKS,
    localparam int CW          = pos_width(ENTRIES, SPAN),
    localparam int AW          = $clog2(ENTRIES),
    localparam int BW          = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1,
    localparam int GW          = NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [KIND_W-1:0]     kind,
    input  logic [POS_W-1:0]      entry_pos,
    input  logic [VALUE_BITS-1:0] write_value,
    input  logic [THR_W-1:0]      threshold,
    input  logic [CW-1:0]         size,
    output logic                  idle,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [SIZE_W-1:0]     res_pos,
    output logic                  res_found,
    output min_ctl_t              ctl,
    output logic [BW-1:0]         blk_addr,
    output logic [GW-1:0]         grp_idx,
    output logic [VALUE_BITS-1:0] wr_val,
    input  logic [VALUE_BITS-1:0] grp_min,
    input  logic [VALUE_BITS-1:0] blk_min,
    output logic                  val_en,
    output logic                  val_we,
    output logic [AW-1:0]         val_addr,
    output logic [VALUE_BITS-1:0] val_wdata,
    input  logic [VALUE_BITS-1:0] val_q
);

    localparam int OW  = $clog2(BLOCK_SIZE);
    localparam int GOW = $clog2(GROUP_BLOCKS);

    localparam logic [CW-1:0]  SPAN_C      = CW'(SPAN);
    localparam logic [CW-1:0]  BS_C        = CW'(BLOCK_SIZE);
    localparam logic [CW-1:0]  ENT_C       = CW'(ENTRIES);
    localparam logic [CW-1:0]  LAST_BLK_C  = CW'(SPAN - BLOCK_SIZE);
    localparam logic [OW-1:0]  OFF_LAST    = OW'(BLOCK_SIZE - 1);
    localparam logic [GOW-1:0] GBO_LAST    = GOW'(GROUP_BLOCKS - 1);
    localparam logic [BW-1:0]  BLK_SKIP    = BW'(GROUP_BLOCKS - 1);
    localparam logic [BW-1:0]  GRP_BLKS    = BW'(GROUP_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC_G,
        S_DEC_B,
        S_WR_UPD,
        S_FWD_ADV,
        S_FWD_BLK,
        S_FWD_VAL,
        S_BWD_ADV,
        S_BWD_BLK,
        S_BWD_VAL,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [THR_W-1:0]      thr_reg, thr_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [OW-1:0]         off_reg, off_next;
    logic [GOW-1:0]        gbo_reg, gbo_next;
    logic [BW-1:0]         blk_reg, blk_next;
    logic [GW-1:0]         grp_reg, grp_next;
    logic [CW-1:0]         bb_reg, bb_next;
    logic [CW-1:0]         gb_reg, gb_next;
    logic [SIZE_W-1:0]     res_pos_reg, res_pos_next;
    logic                  res_found_reg, res_found_next;

    // shared step unit outputs
    logic                  step_bwd;
    logic [CW-1:0]         s_pos;
    logic                  s_wo;
    logic                  s_wg;
    logic [OW-1:0]         s_off;
    logic [GOW-1:0]        s_gbo;
    logic [BW-1:0]         s_blk;
    logic [CW-1:0]         s_bb;
    logic [GW-1:0]         s_grp;
    logic [CW-1:0]         s_gb;

    logic [CW-1:0]         first_pos;
    logic                  grp_skip;
    logic [CW-1:0]         tgt_grp;
    logic [CW-1:0]         tgt_blk;

    function automatic logic below(input logic [VALUE_BITS-1:0] v,
                                   input logic [THR_W-1:0] t);
        return THR_W'(v) < t;
    endfunction

    assign first_pos = CW'(entry_pos);

    // one position step, forward or backward, with block and group carries
    always_comb
    begin
        step_bwd = (state_reg == S_BWD_ADV);
        if (step_bwd)
        begin
            s_pos = pos_reg - 1'b1;
            s_wo  = (off_reg == '0);
            s_wg  = s_wo && (gbo_reg == '0);
            s_off = s_wo ? OFF_LAST : off_reg - 1'b1;
            s_gbo = s_wg ? GBO_LAST : (s_wo ? gbo_reg - 1'b1 : gbo_reg);
            s_blk = s_wo ? blk_reg - 1'b1 : blk_reg;
            s_bb  = s_wo ? bb_reg - BS_C : bb_reg;
            s_grp = s_wg ? grp_reg - 1'b1 : grp_reg;
            s_gb  = s_wg ? gb_reg - SPAN_C : gb_reg;
        end
        else
        begin
            s_pos = pos_reg + 1'b1;
            s_wo  = (off_reg == OFF_LAST);
            s_wg  = s_wo && (gbo_reg == GBO_LAST);
            s_off = s_wo ? '0 : off_reg + 1'b1;
            s_gbo = s_wg ? '0 : (s_wo ? gbo_reg + 1'b1 : gbo_reg);
            s_blk = s_wo ? blk_reg + 1'b1 : blk_reg;
            s_bb  = s_wo ? bb_reg + BS_C : bb_reg;
            s_grp = s_wg ? grp_reg + 1'b1 : grp_reg;
            s_gb  = s_wg ? gb_reg + SPAN_C : gb_reg;
        end
    end

    assign grp_skip = s_wg && !below(grp_min, thr_reg);
    assign tgt_grp  = s_gb + SPAN_C - 1'b1;
    assign tgt_blk  = bb_reg + BS_C - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        thr_next       = thr_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        off_next       = off_reg;
        gbo_next       = gbo_reg;
        blk_next       = blk_reg;
        grp_next       = grp_reg;
        bb_next        = bb_reg;
        gb_next        = gb_reg;
        res_pos_next   = res_pos_reg;
        res_found_next = res_found_reg;
        ctl            = '0;
        blk_addr       = blk_reg;
        grp_idx        = grp_reg;
        val_en         = 1'b0;
        val_we         = 1'b0;
        val_addr       = pos_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next      = kind;
                    thr_next       = threshold;
                    val_next       = write_value;
                    pos_next       = first_pos;
                    rem_next       = first_pos;
                    off_next       = '0;
                    gbo_next       = '0;
                    blk_next       = '0;
                    grp_next       = '0;
                    bb_next        = '0;
                    gb_next        = '0;
                    res_found_next = 1'b0;
                    case (kind)
                        KIND_WRITE:
                        begin
                            if (first_pos < ENT_C)
                                state_next = S_DEC_G;
                        end
                        KIND_FWD, KIND_BWD:
                        begin
                            if (first_pos >= size)
                            begin
                                res_pos_next = (kind == KIND_FWD) ? size[SIZE_W-1:0] : '0;
                                state_next   = S_RESP;
                            end
                            else
                                state_next = S_DEC_G;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end

            // peel whole groups off the start position
            S_DEC_G:
            begin
                if (rem_reg >= SPAN_C)
                begin
                    rem_next = rem_reg - SPAN_C;
                    grp_next = grp_reg + 1'b1;
                    gb_next  = gb_reg + SPAN_C;
                    blk_next = blk_reg + GRP_BLKS;
                    bb_next  = bb_reg + SPAN_C;
                end
                else
                    state_next = S_DEC_B;
            end

            // then whole blocks; the remainder is the offset in the block
            S_DEC_B:
            begin
                if (rem_reg >= BS_C)
                begin
                    rem_next = rem_reg - BS_C;
                    blk_next = blk_reg + 1'b1;
                    gbo_next = gbo_reg + 1'b1;
                    bb_next  = bb_reg + BS_C;
                end
                else
                begin
                    off_next = rem_reg[OW-1:0];
                    val_en   = 1'b1;
                    if (kind_reg == KIND_WRITE)
                    begin
                        val_we     = 1'b1;
                        ctl.blk_rd = 1'b1;
                        state_next = S_WR_UPD;
                    end
                    else if (kind_reg == KIND_FWD)
                        state_next = S_FWD_VAL;
                    else
                        state_next = S_BWD_VAL;
                end
            end

            S_WR_UPD:
            begin
                ctl.blk_wr = 1'b1;
                ctl.grp_wr = 1'b1;
                state_next = S_IDLE;
            end

            S_FWD_ADV:
            begin
                grp_idx = s_grp;
                if (s_pos == size)
                begin
                    res_pos_next = size[SIZE_W-1:0];
                    state_next   = S_RESP;
                end
                else if (grp_skip)
                begin
                    if (tgt_grp >= size)
                    begin
                        res_pos_next = size[SIZE_W-1:0];
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        pos_next = tgt_grp;
                        off_next = OFF_LAST;
                        gbo_next = GBO_LAST;
                        blk_next = s_blk + BLK_SKIP;
                        bb_next  = s_gb + LAST_BLK_C;
                        grp_next = s_grp;
                        gb_next  = s_gb;
                    end
                end
                else
                begin
                    pos_next = s_pos;
                    off_next = s_off;
                    gbo_next = s_gbo;
                    blk_next = s_blk;
                    bb_next  = s_bb;
                    grp_next = s_grp;
                    gb_next  = s_gb;
                    if (s_wo)
                    begin
                        ctl.blk_rd = 1'b1;
                        blk_addr   = s_blk;
                        state_next = S_FWD_BLK;
                    end
                    else
                    begin
                        val_en     = 1'b1;
                        val_addr   = s_pos[AW-1:0];
                        state_next = S_FWD_VAL;
                    end
                end
            end

            S_FWD_BLK:
            begin
                if (!below(blk_min, thr_reg))
                begin
                    if (tgt_blk >= size)
                    begin
                        res_pos_next = size[SIZE_W-1:0];
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        pos_next   = tgt_blk;
                        off_next   = OFF_LAST;
                        state_next = S_FWD_ADV;
                    end
                end
                else
                begin
                    val_en     = 1'b1;
                    state_next = S_FWD_VAL;
                end
            end

            S_FWD_VAL:
            begin
                if (below(val_q, thr_reg))
                begin
                    res_pos_next   = pos_reg[SIZE_W-1:0];
                    res_found_next = 1'b1;
                    state_next     = S_RESP;
                end
                else
                    state_next = S_FWD_ADV;
            end

            S_BWD_ADV:
            begin
                grp_idx = s_grp;
                if (pos_reg == '0)
                begin
                    res_pos_next = '0;
                    state_next   = S_RESP;
                end
                else if (grp_skip)
                begin
                    pos_next = s_gb;
                    off_next = '0;
                    gbo_next = '0;
                    blk_next = s_blk - BLK_SKIP;
                    bb_next  = s_gb;
                    grp_next = s_grp;
                    gb_next  = s_gb;
                end
                else
                begin
                    pos_next = s_pos;
                    off_next = s_off;
                    gbo_next = s_gbo;
                    blk_next = s_blk;
                    bb_next  = s_bb;
                    grp_next = s_grp;
                    gb_next  = s_gb;
                    if (s_wo)
                    begin
                        ctl.blk_rd = 1'b1;
                        blk_addr   = s_blk;
                        state_next = S_BWD_BLK;
                    end
                    else
                    begin
                        val_en     = 1'b1;
                        val_addr   = s_pos[AW-1:0];
                        state_next = S_BWD_VAL;
                    end
                end
            end

            S_BWD_BLK:
            begin
                if (!below(blk_min, thr_reg))
                begin
                    pos_next   = bb_reg;
                    off_next   = '0;
                    state_next = S_BWD_ADV;
                end
                else
                begin
                    val_en     = 1'b1;
                    state_next = S_BWD_VAL;
                end
            end

            S_BWD_VAL:
            begin
                if (below(val_q, thr_reg))
                begin
                    res_pos_next   = pos_reg[SIZE_W-1:0];
                    res_found_next = 1'b1;
                    state_next     = S_RESP;
                end
                else
                    state_next = S_BWD_ADV;
            end

            S_RESP:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_WRITE;
            thr_reg       <= '0;
            val_reg       <= '0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            off_reg       <= '0;
            gbo_reg       <= '0;
            blk_reg       <= '0;
            grp_reg       <= '0;
            bb_reg        <= '0;
            gb_reg        <= '0;
            res_pos_reg   <= '0;
            res_found_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            thr_reg       <= thr_next;
            val_reg       <= val_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            off_reg       <= off_next;
            gbo_reg       <= gbo_next;
            blk_reg       <= blk_next;
            grp_reg       <= grp_next;
            bb_reg        <= bb_next;
            gb_reg        <= gb_next;
            res_pos_reg   <= res_pos_next;
            res_found_reg <= res_found_next;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res_pos   = res_pos_reg;
    assign res_found = res_found_reg;
    assign wr_val    = val_reg;
    assign val_wdata = val_reg;

endmodule

// ===== rtl/core/next_smaller_value_search_top.sv =====
// A write peels off g whole groups, then b whole blocks (g/b = those before the position),
// then writes the value and updates the minima. A search peels off groups and blocks the
// same way, then walks through the shared step unit, with group and block skips and the end
// step, reading values and minima; a start at or beyond the size goes straight to the result.
// One request at a time; ready again in the same cycle the output reg shows the result.
// Reset: minima read as all ones at once (valid bits); no clearing pass.
// ---------------------------------------------------------------------------
// next_smaller_value_search_top
// Value array with block and group minima; forward/backward next-smaller search.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module next_smaller_value_search_top
    import nsv_pkg::*;
#(
    parameter int ENTRIES      = DEF_ENTRIES,
    parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE,
    parameter int GROUP_BLOCKS = DEF_GROUP_BLOCKS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    nsv_req_if.sink           req,
    nsv_rsp_if.source         rsp
);

    localparam int NUM_BLOCKS = (ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int NUM_GROUPS = (NUM_BLOCKS + GROUP_BLOCKS - 1) / GROUP_BLOCKS;
    localparam int CW         = pos_width(ENTRIES, BLOCK_SIZE * GROUP_BLOCKS);
    localparam int AW         = $clog2(ENTRIES);
    localparam int BW         = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
    localparam int GW         = NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1;
    localparam int SIZE_RST   = ENTRIES < (2 ** SIZE_W) ? ENTRIES : (2 ** SIZE_W) - 1;
    localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);

    logic [SIZE_W-1:0]     used_size_reg;
    logic [CW-1:0]         used_ext;
    logic [CW-1:0]         size;

    logic                  walk_idle;
    logic                  res_valid;
    logic                  res_ready;
    logic [SIZE_W-1:0]     res_pos;
    logic                  res_found;
    min_ctl_t              min_ctl;
    logic [BW-1:0]         blk_addr;
    logic [GW-1:0]         grp_idx;
    logic [VALUE_BITS-1:0] wr_val;
    logic [VALUE_BITS-1:0] grp_min;
    logic [VALUE_BITS-1:0] blk_min;
    logic                  val_en;
    logic                  val_we;
    logic [AW-1:0]         val_addr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [VALUE_BITS-1:0] val_q;

    logic                  rsp_vld_reg;
    logic [SIZE_W-1:0]     rsp_pos_reg;
    logic                  rsp_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_size_reg <= SIZE_W'(SIZE_RST);
        else if (cfg_wr_en)
            used_size_reg <= cfg_wr_data;
    end

    // sizes above the array act as the array size
    assign used_ext = CW'(used_size_reg);
    assign size     = (used_ext > ENT_C) ? ENT_C : used_ext;

    assign req.ready = walk_idle;
    assign res_ready = !rsp_vld_reg || rsp.ready;

    nsv_walk #(
        .ENTRIES      (ENTRIES),
        .BLOCK_SIZE   (BLOCK_SIZE),
        .GROUP_BLOCKS (GROUP_BLOCKS)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (req.valid && walk_idle),
        .kind        (req.kind),
        .entry_pos   (req.entry_pos),
        .write_value (req.write_value),
        .threshold   (req.threshold),
        .size        (size),
        .idle        (walk_idle),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_pos     (res_pos),
        .res_found   (res_found),
        .ctl         (min_ctl),
        .blk_addr    (blk_addr),
        .grp_idx     (grp_idx),
        .wr_val      (wr_val),
        .grp_min     (grp_min),
        .blk_min     (blk_min),
        .val_en      (val_en),
        .val_we      (val_we),
        .val_addr    (val_addr),
        .val_wdata   (val_wdata),
        .val_q       (val_q)
    );

    nsv_minima #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_GROUPS (NUM_GROUPS)
    ) u_minima (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (min_ctl),
        .blk_addr (blk_addr),
        .grp_idx  (grp_idx),
        .wr_val   (wr_val),
        .grp_min  (grp_min),
        .blk_min  (blk_min)
    );

    nsv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .en    (val_en),
        .we    (val_we),
        .addr  (val_addr),
        .wdata (val_wdata),
        .rdata (val_q)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (res_valid && res_ready)
            rsp_vld_reg <= 1'b1;
        else if (rsp.ready)
            rsp_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_pos_reg   <= res_pos;
            rsp_found_reg <= res_found;
        end
    end

    assign rsp.valid      = rsp_vld_reg;
    assign rsp.result_pos = rsp_pos_reg;
    assign rsp.found      = rsp_found_reg;

    `NSV_ASSERT_IMP(a_found_in_range, clk, rst_n, (rsp.valid && rsp.found),
        (CW'(rsp.result_pos) < size), "found position not below size")
    `NSV_ASSERT_IMP(a_rsp_from_walk, clk, rst_n, $rose(rsp.valid),
        $past(res_valid), "output word loaded without a finished search")
    `NSV_ASSERT_IMP(a_busy_while_result, clk, rst_n, res_valid,
        !req.ready, "request taken while a result is pending")

endmodule
